>>> rtl/owdm_pkg.sv
// owdm_pkg: shared constants, widths and per-motor calibration for the omni drive mixer.
// No dependencies; used by the interfaces and by the top level.
`timescale 1ns / 1ps

package owdm_pkg;

	// Field widths
	localparam int ANGLE_BITS = 12;
	localparam int SPEED_W    = 16;
	localparam int DUTY_W     = 8;
	localparam int MAG_W      = 16;
	localparam int NWHEEL     = 3;

	// Angle constants, in 1/2^ANGLE_BITS turn
	localparam int QUARTER = 1 << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] MOUNT_RESET = ANGLE_BITS'(446);
	localparam logic [ANGLE_BITS-1:0] OFF_W2 = ANGLE_BITS'((2 * (1 << ANGLE_BITS) + 1) / 3);
	localparam logic [ANGLE_BITS-1:0] OFF_W3 = ANGLE_BITS'(((1 << ANGLE_BITS) + 1) / 3);

	// Unit sine in Q15
	localparam logic [MAG_W-1:0] ONE_Q15 = MAG_W'(32768);

	// Sine table generator constant: pi/2 in Q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Wheel rate scale: 14.2419 in Q16
	localparam int W_W = 31;
	localparam logic [19:0] W_SCALE = 20'd933357;

	// Motor three extra gain: 0.68 in Q16
	localparam logic [15:0] M3_SCALE = 16'd44564;

	// Calibration per motor: breakpoint, high and low segment slope and offset
	typedef logic [W_W-1:0] w_t;
	typedef logic [12:0]    coef_t;
	typedef logic [31:0]    cofs_t;

	localparam w_t    THR [NWHEEL] = '{31'd260178, 31'd212337, 31'd260178};
	localparam coef_t KH  [NWHEEL] = '{13'd5171, 13'd4856, 13'd4856};
	localparam cofs_t CH  [NWHEEL] = '{32'd536870912, 32'd237502464, 32'd237502464};
	localparam coef_t KL  [NWHEEL] = '{13'd823, 13'd1009, 13'd1009};
	localparam cofs_t CL  [NWHEEL] = '{32'd644218880, 32'd644218880, 32'd644218880};
	localparam logic  M3G [NWHEEL] = '{1'b0, 1'b0, 1'b1};

	// Voltage widths: V below 2^33 is exact, above that the duty saturates
	localparam int V_W  = 33;
	localparam int VS_W = 46;

	localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

endpackage

>>> rtl/owdm_if.sv
// owdm_if: valid/ready channels for command, result and configuration transfers.
// Depends on owdm_pkg for field widths.
`timescale 1ns / 1ps

interface owdm_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [owdm_pkg::ANGLE_BITS-1:0]    heading;
	logic [owdm_pkg::SPEED_W-1:0]       speed;
	modport source (output valid, heading, speed, input ready);
	modport sink   (input valid, heading, speed, output ready);
endinterface

interface owdm_res_if;
	logic                           valid;
	logic                           ready;
	logic [owdm_pkg::DUTY_W-1:0]    wheel1_duty;
	logic                           wheel1_reverse;
	logic [owdm_pkg::DUTY_W-1:0]    wheel2_duty;
	logic                           wheel2_reverse;
	logic [owdm_pkg::DUTY_W-1:0]    wheel3_duty;
	logic                           wheel3_reverse;
	modport source (output valid, wheel1_duty, wheel1_reverse, wheel2_duty, wheel2_reverse,
		wheel3_duty, wheel3_reverse, input ready);
	modport sink   (input valid, wheel1_duty, wheel1_reverse, wheel2_duty, wheel2_reverse,
		wheel3_duty, wheel3_reverse, output ready);
endinterface

interface owdm_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [owdm_pkg::ANGLE_BITS-1:0]    data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> rtl/omni_wheel_drive_mixer.sv
// omni_wheel_drive_mixer: pipelined three-wheel omni drive kinematics to PWM duty.
// Depends on owdm_pkg and the channel interfaces in owdm_if.sv.
//
//   channel | dir | payload                                   | transfer
//   cmd     | in  | heading[11:0], speed[15:0]                | valid & ready
//   res     | out | wheelN_duty[7:0], wheelN_reverse (N=1..3) | valid & ready
//   cfg     | in  | data[11:0] = mount_offset                 | valid & ready
//
// One command per clock unless a result waits and res.ready is low. A command passes stages 1 to 4,
// the 16-stage restoring divider (one quotient bit per stage), stages e1 to e4 and the output register.
// The sine table is a ROM per wheel with registered read data.
// arst_n clears all valid bits and sets mount_offset to 446; no clearing pass.
// The whole pipeline holds while a result waits and res.ready is low.
`timescale 1ns / 1ps

module omni_wheel_drive_mixer #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	owdm_cmd_if.sink      cmd,
	owdm_res_if.source    res,
	owdm_cfg_if.sink      cfg
);

	localparam int AB    = owdm_pkg::ANGLE_BITS;
	localparam int NW    = owdm_pkg::NWHEEL;
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int PW    = (AB - 2) + IDX_W + 1;
	localparam int MW    = owdm_pkg::MAG_W;
	localparam int SW    = owdm_pkg::SPEED_W;
	localparam int DB    = SW;
	localparam int RW    = 32;
	localparam int WW    = owdm_pkg::W_W;
	localparam int VW    = owdm_pkg::V_W;
	localparam int VSW   = owdm_pkg::VS_W;

	typedef logic [15:0] sin_rom_t [SINE_TABLE_DEPTH];

	// Reciprocals ceil(2^64 / d) for exact division in the table generator
	localparam logic [127:0] DEPTH_RCP = ((128'd1 << 64) + 128'(SINE_TABLE_DEPTH) - 128'd1)
		/ 128'(SINE_TABLE_DEPTH);
	localparam logic [127:0] TAYLOR_RCP [7] = '{
		((128'd1 << 64) + 128'd5) / 128'd6,
		((128'd1 << 64) + 128'd19) / 128'd20,
		((128'd1 << 64) + 128'd41) / 128'd42,
		((128'd1 << 64) + 128'd71) / 128'd72,
		((128'd1 << 64) + 128'd109) / 128'd110,
		((128'd1 << 64) + 128'd155) / 128'd156,
		((128'd1 << 64) + 128'd209) / 128'd210
	};

	// Build the quarter-wave sine table from a Taylor series in Q30
	function automatic sin_rom_t build_sin_rom();
		sin_rom_t         rom;
		longint unsigned  x;
		longint unsigned  x2;
		longint unsigned  term;
		longint           sum;
		longint unsigned  q;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			x    = 64'((128'(longint'(k) * owdm_pkg::HALF_PI_Q30) * DEPTH_RCP) >> 64);
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int n = 1; n <= 7; n++) begin
				term = 64'((128'((term * x2) >> 30) * TAYLOR_RCP[n - 1]) >> 64);
				if (n % 2 == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			q = (longint'(sum) + 64'd16384) >> 15;
			if (q > 64'd32768)
				q = 64'd32768;
			rom[k] = q[15:0];
		end
		return rom;
	endfunction

	localparam sin_rom_t SIN_ROM = build_sin_rom();

	localparam logic [AB-1:0] OFFS [NW] = '{'0, owdm_pkg::OFF_W2, owdm_pkg::OFF_W3};

	logic en;
	logic res_valid_q;

	// Advance the whole pipeline unless a result waits untaken
	assign en        = !res_valid_q || res.ready;
	assign cmd.ready = en;
	assign cfg.ready = 1'b1;

	// Hold the mount offset register
	logic [AB-1:0] mount_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mount_q <= owdm_pkg::MOUNT_RESET;
		else if (cfg.valid)
			mount_q <= cfg.data;
	end

	// Stage 1: wheel angles, quadrant fold, table index
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1 [NW];
	logic             full_s1 [NW];
	logic             neg_s1 [NW];
	logic [SW-1:0]    speed_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= cmd.valid;
	end

	for (genvar i = 0; i < NW; i++) begin : g_ang
		logic [AB-1:0] a;
		logic [AB-2:0] p;
		logic [PW-1:0] ip;
		always_comb begin
			a  = cmd.heading - mount_q - OFFS[i];
			p  = a[AB-2] ? ((AB-1)'(owdm_pkg::QUARTER) - {1'b0, a[AB-3:0]})
				: {1'b0, a[AB-3:0]};
			ip = PW'(p[AB-3:0]) * PW'(SINE_TABLE_DEPTH);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				idx_s1[i]  <= ip[AB-2 +: IDX_W];
				full_s1[i] <= p[AB-2];
				neg_s1[i]  <= a[AB-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			speed_s1 <= cmd.speed;
	end

	// Stage 2: read the sine ROM
	logic          v_s2;
	logic [15:0]   rom_s2 [NW];
	logic          full_s2 [NW];
	logic          neg_s2 [NW];
	logic [SW-1:0] speed_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				rom_s2[i]  <= SIN_ROM[idx_s1[i]];
				full_s2[i] <= full_s1[i];
				neg_s2[i]  <= neg_s1[i];
			end
			speed_s2 <= speed_s1;
		end
	end

	// Stage 3: magnitudes and their maximum
	logic          v_s3;
	logic [MW-1:0] mag_s3 [NW];
	logic          neg_s3 [NW];
	logic [MW-1:0] m_s3;
	logic [SW-1:0] speed_s3;
	logic [MW-1:0] mag_c [NW];
	logic [MW-1:0] m_c;

	always_comb begin
		for (int i = 0; i < NW; i++)
			mag_c[i] = full_s2[i] ? owdm_pkg::ONE_Q15 : rom_s2[i];
		m_c = mag_c[0];
		for (int i = 1; i < NW; i++)
			if (mag_c[i] > m_c)
				m_c = mag_c[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				mag_s3[i] <= mag_c[i];
				neg_s3[i] <= neg_s2[i];
			end
			m_s3     <= m_c;
			speed_s3 <= speed_s2;
		end
	end

	// Stage 4: dividend speed * magnitude
	logic          v_s4;
	logic [RW-1:0] prod_s4 [NW];
	logic          pos_s4 [NW];
	logic [MW-1:0] m_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				prod_s4[i] <= RW'(speed_s3) * RW'(mag_s3[i]);
				pos_s4[i]  <= !neg_s3[i] && (mag_s3[i] != '0);
			end
			m_s4 <= m_s3;
		end
	end

	// Divider: one quotient bit per stage, most significant first
	logic          dv    [DB];
	logic [RW-1:0] drem  [DB][NW];
	logic [DB-1:0] dq    [DB][NW];
	logic          dpos  [DB][NW];
	logic [MW-1:0] dm    [DB];

	for (genvar k = 0; k < DB; k++) begin : g_div
		localparam int B = DB - 1 - k;
		logic          v_in;
		logic [MW-1:0] m_in;
		logic [RW-1:0] rem_in [NW];
		logic [DB-1:0] q_in [NW];
		logic          pos_in [NW];
		logic [RW-1:0] dsub;

		// Take operands from stage 4 or from the previous divider stage
		if (k == 0) begin : g_first
			always_comb begin
				v_in = v_s4;
				m_in = m_s4;
				for (int i = 0; i < NW; i++) begin
					rem_in[i] = prod_s4[i];
					q_in[i]   = '0;
					pos_in[i] = pos_s4[i];
				end
			end
		end else begin : g_next
			always_comb begin
				v_in = dv[k-1];
				m_in = dm[k-1];
				for (int i = 0; i < NW; i++) begin
					rem_in[i] = drem[k-1][i];
					q_in[i]   = dq[k-1][i];
					pos_in[i] = dpos[k-1][i];
				end
			end
		end

		assign dsub = RW'(m_in) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv[k] <= 1'b0;
			else if (en)
				dv[k] <= v_in;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dm[k] <= m_in;
				for (int i = 0; i < NW; i++) begin
					dpos[k][i] <= pos_in[i];
					if (rem_in[i] >= dsub) begin
						drem[k][i] <= rem_in[i] - dsub;
						dq[k][i]   <= q_in[i] | (DB'(1) << B);
					end else begin
						drem[k][i] <= rem_in[i];
						dq[k][i]   <= q_in[i];
					end
				end
			end
		end
	end

	// Stage e1: wheel rate W = u * 14.2419 in Q1 (the Q16 scale product shifted right by 15)
	logic          v_e1;
	logic [WW-1:0] w_e1 [NW];
	logic          fwd_e1 [NW];
	logic [DB-1:0] u_c [NW];
	logic [35:0]   wp_c [NW];

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			u_c[i]  = (dm[DB-1] == '0) ? '0 : dq[DB-1][i];
			wp_c[i] = 36'(u_c[i]) * 36'(owdm_pkg::W_SCALE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_e1 <= 1'b0;
		else if (en)
			v_e1 <= dv[DB-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				w_e1[i]   <= WW'(wp_c[i] >> 15);
				fwd_e1[i] <= dpos[DB-1][i] && (u_c[i] != '0);
			end
		end
	end

	// Stage e2: both calibration segment products and the breakpoint test
	logic          v_e2;
	logic [43:0]   ph_e2 [NW];
	logic [43:0]   pl_e2 [NW];
	logic          hi_e2 [NW];
	logic          fwd_e2 [NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_e2 <= 1'b0;
		else if (en)
			v_e2 <= v_e1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				ph_e2[i]  <= 44'(w_e1[i]) * 44'(owdm_pkg::KH[i]);
				pl_e2[i]  <= 44'(w_e1[i]) * 44'(owdm_pkg::KL[i]);
				hi_e2[i]  <= w_e1[i] > owdm_pkg::THR[i];
				fwd_e2[i] <= fwd_e1[i];
			end
		end
	end

	// Stage e3: select segment, clamp negative to zero, flag saturation
	logic            v_e3;
	logic [VW-1:0]   v_val_e3 [NW];
	logic            sat_e3 [NW];
	logic            hi_e3 [NW];
	logic            fwd_e3 [NW];
	logic signed [VSW-1:0] vs_c [NW];

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			if (hi_e2[i])
				vs_c[i] = signed'({2'b00, ph_e2[i]}) - signed'(VSW'(owdm_pkg::CH[i]));
			else
				vs_c[i] = signed'({2'b00, pl_e2[i]}) + signed'(VSW'(owdm_pkg::CL[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_e3 <= 1'b0;
		else if (en)
			v_e3 <= v_e2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				if (vs_c[i] < 0) begin
					v_val_e3[i] <= '0;
					sat_e3[i]   <= 1'b0;
				end else begin
					v_val_e3[i] <= vs_c[i][VW-1:0];
					sat_e3[i]   <= vs_c[i][VSW-1:VW] != '0;
				end
				hi_e3[i]  <= hi_e2[i];
				fwd_e3[i] <= fwd_e2[i];
			end
		end
	end

	// Stage e4: motor three high segment gain
	logic          v_e4;
	logic [VW-1:0] v_val_e4 [NW];
	logic          sat_e4 [NW];
	logic          fwd_e4 [NW];
	logic [VW+15:0] g_c [NW];

	always_comb begin
		for (int i = 0; i < NW; i++)
			g_c[i] = (VW+16)'(v_val_e3[i]) * (VW+16)'(owdm_pkg::M3_SCALE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_e4 <= 1'b0;
		else if (en)
			v_e4 <= v_e3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				if (owdm_pkg::M3G[i] && hi_e3[i])
					v_val_e4[i] <= g_c[i][16 +: VW];
				else
					v_val_e4[i] <= v_val_e3[i];
				sat_e4[i] <= sat_e3[i];
				fwd_e4[i] <= fwd_e3[i];
			end
		end
	end

	// Output register: duty = 255 * V / 2^32, saturated
	logic [owdm_pkg::DUTY_W-1:0] duty_q [NW];
	logic                        rev_q [NW];
	logic [VW+7:0]               dp_c [NW];

	always_comb begin
		for (int i = 0; i < NW; i++)
			dp_c[i] = (VW+8)'(v_val_e4[i]) * (VW+8)'(255);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (en)
			res_valid_q <= v_e4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NW; i++) begin
				if (sat_e4[i] || dp_c[i][VW+7:40] != '0)
					duty_q[i] <= owdm_pkg::DUTY_MAX;
				else
					duty_q[i] <= dp_c[i][39:32];
				rev_q[i] <= !fwd_e4[i];
			end
		end
	end

	assign res.valid          = res_valid_q;
	assign res.wheel1_duty    = duty_q[0];
	assign res.wheel1_reverse = rev_q[0];
	assign res.wheel2_duty    = duty_q[1];
	assign res.wheel2_reverse = rev_q[1];
	assign res.wheel3_duty    = duty_q[2];
	assign res.wheel3_reverse = rev_q[2];

`ifndef SYNTHESIS
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> v_s1)
		else $error("accepted command did not enter stage 1");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv[DB-1] && dm[DB-1] != '0 |-> drem[DB-1][0] < RW'(dm[DB-1])
			&& drem[DB-1][1] < RW'(dm[DB-1]) && drem[DB-1][2] < RW'(dm[DB-1]))
		else $error("divider remainder not below divisor");

	a_duty_floor: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.wheel1_duty >= 8'd38 && res.wheel2_duty >= 8'd38
			&& res.wheel3_duty >= 8'd38)
		else $error("duty below calibration floor");

	a_not_all_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.wheel1_reverse || res.wheel2_reverse || res.wheel3_reverse)
		else $error("all three wheels forward");
`endif

endmodule
